// ===== rtl/gis_pkg.sv =====
// shared types and constants of the gray image statistics block
// depends on nothing; used by every module of the block
package gis_pkg;

	// image size limit and field widths
	localparam int MAX_PIXELS = 1048576;
	localparam int LEVEL_W    = 8;
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W      = LEVEL_W + CNT_W;
	localparam int CON_FRAC   = 15;
	localparam int CON_W      = CON_FRAC + 1;
	localparam int TOT_W      = LEVEL_W + 1;

	// queue of image totals between accumulator and dividers
	localparam int QDEPTH   = 2;
	localparam int Q_PTR_W  = $clog2(QDEPTH);
	localparam int Q_FILL_W = $clog2(QDEPTH + 1);

	// divider step counts
	localparam int MEAN_STEPS = LEVEL_W;
	localparam int STEPS      = CON_W;
	localparam int STEP_W     = $clog2(STEPS);

	// reset values of the running extremes
	localparam logic [LEVEL_W-1:0] MIN_INIT = '1;
	localparam logic [LEVEL_W-1:0] MAX_INIT = '0;

	// totals of one finished image
	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [CNT_W-1:0]   count;
		logic [LEVEL_W-1:0] lo;
		logic [LEVEL_W-1:0] hi;
	} gis_rec_t;

endpackage

// ===== rtl/gray_image_statistics_top.sv =====
// Gray image statistics: one pixel request per cycle while the queue has room, each image's
// mean, minimum, maximum and Michelson contrast returned as a single result request after
// its last pixel. A two-entry queue of image totals sits between the accumulator and the
// shared shift-subtract dividers; each result loads the totals and then takes one contrast
// quotient bit per step, with the 8 mean bits in the first 8 steps, so the input streams
// without stalls while the dividers and the result side keep up, and stalls once the queue
// fills. Pixels past MAX_PIXELS are ignored, and an all-black image reports contrast 0 with
// contrast_undefined set. Depends on gis_pkg, gis_front, gis_queue and gis_back.
module gray_image_statistics_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [gis_pkg::LEVEL_W-1:0]  pixel_level,
	input  logic                         last_pixel,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gis_pkg::LEVEL_W-1:0]  mean_level,
	output logic [gis_pkg::LEVEL_W-1:0]  min_level,
	output logic [gis_pkg::LEVEL_W-1:0]  max_level,
	output logic [gis_pkg::CON_W-1:0]    contrast_q15,
	output logic                         contrast_undefined
);
	import gis_pkg::*;

	logic     push;
	gis_rec_t push_rec;
	logic     q_full;
	logic     pop;
	logic     avail;
	gis_rec_t head;

	// accumulate pixels of the current image
	gis_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_level (pixel_level),
		.last_pixel  (last_pixel),
		.q_full      (q_full),
		.push        (push),
		.push_rec    (push_rec)
	);

	// finished image totals waiting for the dividers
	gis_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	// divide and register the result
	gis_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.avail              (avail),
		.head               (head),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.mean_level         (mean_level),
		.min_level          (min_level),
		.max_level          (max_level),
		.contrast_q15       (contrast_q15),
		.contrast_undefined (contrast_undefined)
	);

endmodule

// ===== rtl/gis_front.sv =====
// pixel accumulator: running sum, count, minimum and maximum of one image
// depends on gis_pkg; pushes image totals into gis_queue
module gis_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [gis_pkg::LEVEL_W-1:0]  pixel_level,
	input  logic                         last_pixel,
	input  logic                         q_full,
	output logic                         push,
	output gis_pkg::gis_rec_t            push_rec
);
	import gis_pkg::*;

	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [LEVEL_W-1:0] min_q;
	logic [LEVEL_W-1:0] max_q;
	logic [SUM_W-1:0]   sum_nx;
	logic [CNT_W-1:0]   count_nx;
	logic [LEVEL_W-1:0] min_nx;
	logic [LEVEL_W-1:0] max_nx;
	logic               accept;
	logic               take;

	// hold the source only when no queue slot is left
	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign take     = count_q < CNT_W'(MAX_PIXELS);

	// totals including the current pixel, pixels past the limit ignored
	always_comb begin
		sum_nx   = sum_q;
		count_nx = count_q;
		min_nx   = min_q;
		max_nx   = max_q;
		if (take) begin
			sum_nx   = sum_q + SUM_W'(pixel_level);
			count_nx = count_q + CNT_W'(1);
			if (pixel_level < min_q)
				min_nx = pixel_level;
			if (pixel_level > max_q)
				max_nx = pixel_level;
		end
	end

	assign push           = accept & last_pixel;
	assign push_rec.sum   = sum_nx;
	assign push_rec.count = count_nx;
	assign push_rec.lo    = min_nx;
	assign push_rec.hi    = max_nx;

	// accumulators, cleared when the image ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= MIN_INIT;
			max_q   <= MAX_INIT;
		end else if (accept) begin
			if (last_pixel) begin
				sum_q   <= '0;
				count_q <= '0;
				min_q   <= MIN_INIT;
				max_q   <= MAX_INIT;
			end else begin
				sum_q   <= sum_nx;
				count_q <= count_nx;
				min_q   <= min_nx;
				max_q   <= max_nx;
			end
		end
	end

endmodule

// ===== rtl/gis_queue.sv =====
// short queue of finished image totals between accumulator and dividers
// depends on gis_pkg
module gis_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gis_pkg::gis_rec_t  push_rec,
	output logic               full,
	input  logic               pop,
	output logic               avail,
	output gis_pkg::gis_rec_t  head
);
	import gis_pkg::*;

	gis_rec_t             mem_q [QDEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_FILL_W-1:0]  fill_q;

	assign full  = fill_q == Q_FILL_W'(QDEPTH);
	assign avail = fill_q != '0;
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + Q_FILL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - Q_FILL_W'(1);
		end
	end

endmodule

// ===== rtl/gis_back.sv =====
// shift-subtract dividers for mean and contrast, plus the result register
// depends on gis_pkg; pops image totals from gis_queue
module gis_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         avail,
	input  gis_pkg::gis_rec_t            head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gis_pkg::LEVEL_W-1:0]  mean_level,
	output logic [gis_pkg::LEVEL_W-1:0]  min_level,
	output logic [gis_pkg::LEVEL_W-1:0]  max_level,
	output logic [gis_pkg::CON_W-1:0]    contrast_q15,
	output logic                         contrast_undefined
);
	import gis_pkg::*;

	localparam int CR_W = TOT_W + 1;

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W:0]      mrem_q;
	logic [LEVEL_W-1:0]  mbits_q;
	logic [CNT_W-1:0]    div_q;
	logic [LEVEL_W-1:0]  mquo_q;
	logic [CR_W-1:0]     crem_q;
	logic [TOT_W-1:0]    tot_q;
	logic [CON_W-1:0]    cquo_q;
	logic [LEVEL_W-1:0]  lo_q;
	logic [LEVEL_W-1:0]  hi_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  mean_q;
	logic [LEVEL_W-1:0]  min_q;
	logic [LEVEL_W-1:0]  max_q;
	logic [CON_W-1:0]    con_q;
	logic                undef_q;

	logic                mean_act;
	logic [CNT_W:0]      mtrial;
	logic                mge;
	logic [CR_W-1:0]     ctrial;
	logic                cge;
	logic [CON_W-1:0]    cquo_nx;
	logic                last_step;
	logic                out_free;
	logic                advance;

	assign pop = avail & ~busy_q;

	// mean step: one quotient bit, dividend low bits shifted in
	assign mean_act = step_q < STEP_W'(MEAN_STEPS);
	assign mtrial   = {mrem_q[CNT_W-1:0], mbits_q[LEVEL_W-1]};
	assign mge      = mtrial >= {1'b0, div_q};

	// contrast step: first step tests the integer bit without doubling
	assign ctrial  = (step_q == '0) ? crem_q : {crem_q[CR_W-2:0], 1'b0};
	assign cge     = ctrial >= {1'b0, tot_q};
	assign cquo_nx = {cquo_q[CON_W-2:0], cge};

	assign last_step = step_q == STEP_W'(STEPS - 1);
	assign out_free  = ~out_valid_q | ~out_stall;
	assign advance   = busy_q & (~last_step | out_free);

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			mrem_q  <= {1'b0, head.sum[SUM_W-1:LEVEL_W]};
			mbits_q <= head.sum[LEVEL_W-1:0];
			div_q   <= head.count;
			mquo_q  <= '0;
			crem_q  <= CR_W'(head.hi - head.lo);
			tot_q   <= TOT_W'(head.hi) + TOT_W'(head.lo);
			cquo_q  <= '0;
			lo_q    <= head.lo;
			hi_q    <= head.hi;
		end else if (advance) begin
			if (mean_act) begin
				mrem_q  <= mge ? mtrial - {1'b0, div_q} : mtrial;
				mbits_q <= {mbits_q[LEVEL_W-2:0], 1'b0};
				mquo_q  <= {mquo_q[LEVEL_W-2:0], mge};
			end
			crem_q <= cge ? ctrial - {1'b0, tot_q} : ctrial;
			cquo_q <= cquo_nx;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && last_step) begin
			mean_q  <= mquo_q;
			min_q   <= lo_q;
			max_q   <= hi_q;
			undef_q <= tot_q == '0;
			con_q   <= (tot_q == '0) ? '0 : cquo_nx;
		end
	end

	// step sequencing and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance) begin
				if (last_step) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (advance && last_step)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid          = out_valid_q;
	assign mean_level         = mean_q;
	assign min_level          = min_q;
	assign max_level          = max_q;
	assign contrast_q15       = con_q;
	assign contrast_undefined = undef_q;

	// step counter rests at zero while idle
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> step_q == '0)
		else $error("step counter moved while divider idle");

	// a finished image never reports min above max
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> min_q <= max_q)
		else $error("result minimum above maximum");

	// undefined contrast only for an all-black image
	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && undef_q |-> con_q == '0 && max_q == '0 && mean_q == '0)
		else $error("undefined contrast with nonzero levels");

	// contrast never exceeds one
	a_con_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> con_q <= CON_W'(1 << CON_FRAC))
		else $error("contrast above one");

endmodule

// ===== dv/tb.sv =====
// testbench of gray_image_statistics_top: a directed pixel table, one long image with no
// idling and random images, each result checked against a typed row or a local predictor
// depends on gis_pkg and the RTL of the gray image statistics block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gis_pkg::*;

	// one image result as the block reports it
	typedef struct packed {
		logic [LEVEL_W-1:0] mean;
		logic [LEVEL_W-1:0] lo;
		logic [LEVEL_W-1:0] hi;
		logic [CON_W-1:0]   contrast;
		logic               undef;
	} image_stats_t;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
		logic               typed;
		image_stats_t       stats;
	} pixel_row_t;

	// content styles of random images
	typedef enum {FILL_UNIFORM, FILL_BLACK, FILL_NARROW, FILL_EXTREMES} fill_t;

	localparam image_stats_t NO_STATS = '0;
	localparam int TABLE_ROWS   = 20;
	localparam int LONG_IMAGE   = 300;
	localparam int RANDOM_ITEMS = 1400;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 64;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [LEVEL_W-1:0] pixel_level = '0;
	logic               last_pixel  = 1'b0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [LEVEL_W-1:0] mean_level;
	logic [LEVEL_W-1:0] min_level;
	logic [LEVEL_W-1:0] max_level;
	logic [CON_W-1:0]   contrast_q15;
	logic               contrast_undefined;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int mismatch_count = 0;

	// totals of the image now streaming in
	logic [SUM_W-1:0]   acc_sum;
	logic [CNT_W-1:0]   acc_count;
	logic [LEVEL_W-1:0] acc_lo;
	logic [LEVEL_W-1:0] acc_hi;

	// image results still to come out of the block, oldest first
	image_stats_t pending_stats[$];

	// directed pixels: extremes, all-black images, alternating bit patterns
	pixel_row_t stim_table [0:TABLE_ROWS-1] = '{
		'{8'd0,   1'b1, 1'b1, '{8'd0,   8'd0,   8'd0,   16'd0,     1'b1}},
		'{8'd255, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255, 16'd0,     1'b0}},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd255, 1'b1, 1'b1, '{8'd127, 8'd0,   8'd255, 16'd32768, 1'b0}},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b1, 1'b1, '{8'd0,   8'd0,   8'd0,   16'd0,     1'b1}},
		'{8'd1,   1'b1, 1'b1, '{8'd1,   8'd1,   8'd1,   16'd0,     1'b0}},
		'{8'd128, 1'b0, 1'b0, NO_STATS},
		'{8'd64,  1'b0, 1'b0, NO_STATS},
		'{8'd200, 1'b0, 1'b0, NO_STATS},
		'{8'd3,   1'b1, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd254, 1'b1, 1'b0, NO_STATS},
		'{8'd85,  1'b0, 1'b0, NO_STATS},
		'{8'd170, 1'b1, 1'b0, NO_STATS},
		'{8'd255, 1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b0, 1'b0, NO_STATS},
		'{8'd0,   1'b1, 1'b1, '{8'd63,  8'd0,   8'd255, 16'd32768, 1'b0}}
	};

	gray_image_statistics_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.pixel_level        (pixel_level),
		.last_pixel         (last_pixel),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.mean_level         (mean_level),
		.min_level          (min_level),
		.max_level          (max_level),
		.contrast_q15       (contrast_q15),
		.contrast_undefined (contrast_undefined)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL gray_image_statistics_top");
		$finish;
	end

	task automatic clear_totals();
		acc_sum   = '0;
		acc_count = '0;
		acc_lo    = MIN_INIT;
		acc_hi    = MAX_INIT;
	endtask

	// mean, extremes and michelson contrast of the finished image
	function automatic image_stats_t image_result();
		image_stats_t             s;
		logic [TOT_W-1:0]         total;
		logic [CON_W+LEVEL_W-1:0] scaled;
		total  = TOT_W'(acc_hi) + TOT_W'(acc_lo);
		s.mean = LEVEL_W'(acc_sum / acc_count);
		s.lo   = acc_lo;
		s.hi   = acc_hi;
		if (total == 0) begin
			s.contrast = '0;
			s.undef    = 1'b1;
		end else begin
			scaled     = (CON_W+LEVEL_W)'(acc_hi - acc_lo) << CON_FRAC;
			s.contrast = CON_W'(scaled / total);
			s.undef    = 1'b0;
		end
		return s;
	endfunction

	// fold one accepted pixel into the totals; pixels past the limit are dropped
	task automatic accumulate_pixel(input logic [LEVEL_W-1:0] level, input logic last,
			input logic typed, input image_stats_t typed_stats);
		if (acc_count < MAX_PIXELS) begin
			acc_sum   += SUM_W'(level);
			acc_count += CNT_W'(1);
			if (level < acc_lo)
				acc_lo = level;
			if (level > acc_hi)
				acc_hi = level;
		end
		if (last) begin
			pending_stats.push_back(typed ? typed_stats : image_result());
			clear_totals();
		end
	endtask

	// drive one pixel request and wait until it is taken
	task automatic send_pixel(input logic [LEVEL_W-1:0] level, input logic last,
			input logic typed = 1'b0, input image_stats_t typed_stats = '0);
		while (tx_idle_on && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_level <= level;
		last_pixel  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accumulate_pixel(level, last, typed, typed_stats);
	endtask

	// result side: random stalls and compare against the oldest expected image
	always @(posedge clk) begin
		image_stats_t got;
		image_stats_t want;
		out_stall <= rx_idle_on && ($urandom_range(99) < 7);
		if (arst_n && out_valid && !out_stall) begin
			got = '{mean_level, min_level, max_level, contrast_q15, contrast_undefined};
			if (pending_stats.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected result: mean %0d min %0d max %0d contrast %0d undef %0b",
						got.mean, got.lo, got.hi, got.contrast, got.undef);
				mismatch_count++;
			end else begin
				want = pending_stats.pop_front();
				if (got !== want) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("mismatch expected: mean %0d min %0d max %0d contrast %0d undef %0b",
							want.mean, want.lo, want.hi, want.contrast, want.undef);
						$display("         actual:   mean %0d min %0d max %0d contrast %0d undef %0b",
							got.mean, got.lo, got.hi, got.contrast, got.undef);
					end
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int                 sent;
		int                 len;
		int                 r;
		int                 tmp;
		int                 base;
		bit                 paused;
		fill_t              fill;
		logic [LEVEL_W-1:0] level;
		sent   = 0;
		paused = 1'b0;
		clear_totals();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_table[i])
			send_pixel(stim_table[i].level, stim_table[i].last, stim_table[i].typed,
				stim_table[i].stats);

		// one long image, streamed with no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int k = 0; k < LONG_IMAGE; k++)
			send_pixel(8'd200, 1'b0);
		// a mid-level pixel, then both extremes, the marked one ends the image
		send_pixel(8'd100, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// random images of mostly short length
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 15)
				len = 1;
			else if (r < 55)
				len = $urandom_range(15, 2);
			else if (r < 90)
				len = $urandom_range(64, 16);
			else
				len = $urandom_range(200, 65);
			r = $urandom_range(99);
			fill = (r < 10) ? FILL_BLACK : (r < 30) ? FILL_NARROW :
				(r < 45) ? FILL_EXTREMES : FILL_UNIFORM;
			base = $urandom_range(255);
			for (int k = 0; k < len; k++) begin
				case (fill)
					FILL_BLACK: begin
						level = '0;
					end
					FILL_NARROW: begin
						tmp   = base + $urandom_range(7);
						level = (tmp > 255) ? 8'd255 : tmp[LEVEL_W-1:0];
					end
					FILL_EXTREMES: begin
						r     = $urandom_range(3);
						level = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 :
							LEVEL_W'($urandom_range(255));
					end
					default: begin
						level = LEVEL_W'($urandom_range(255));
					end
				endcase
				send_pixel(level, k == len - 1);
			end
			sent += len;

			// hold off once until the block has delivered everything
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_stats.size() != 0)
					@(posedge clk);
			end
		end

		// drain and finish
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS gray_image_statistics_top");
		else
			$display("FAIL gray_image_statistics_top");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gis_pkg.sv
rtl/gis_front.sv
rtl/gis_queue.sv
rtl/gis_back.sv
rtl/gray_image_statistics_top.sv
dv/tb.sv
